### hdl/ptvdf_pkg.sv
`default_nettype none
package ptvdf_pkg;
  localparam int unsigned CoordW = 21;
  localparam int unsigned KeyW = 18;
  localparam int unsigned PackedKeyW = 54;
  localparam int unsigned RegW = 63;
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned InDataW = 72;
  localparam int unsigned OutDataW = 72;
  localparam logic [63:0] HashMul = 64'd16777619;

  localparam logic [RegIdxW-1:0] REG_EXT_ROW0 = 3'd0;
  localparam logic [RegIdxW-1:0] REG_EXT_ROW1 = 3'd1;
  localparam logic [RegIdxW-1:0] REG_EXT_ROW2 = 3'd2;
  localparam logic [RegIdxW-1:0] REG_EXT_OFS = 3'd3;
  localparam logic [RegIdxW-1:0] REG_POSE_ROW0 = 3'd4;
  localparam logic [RegIdxW-1:0] REG_POSE_ROW1 = 3'd5;
  localparam logic [RegIdxW-1:0] REG_POSE_ROW2 = 3'd6;
  localparam logic [RegIdxW-1:0] REG_POSE_OFS = 3'd7;

  localparam logic [RegW-1:0] RowReset0 = 63'd262144;
  localparam logic [RegW-1:0] RowReset1 = 63'd549755813888;
  localparam logic [RegW-1:0] RowReset2 = 63'd1152921504606846976;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic [PackedKeyW-1:0] vkey_t;
endpackage
`default_nettype wire

### hdl/point_transform_voxel_dedup_filter.sv
`default_nettype none
// channel | dir | payload
// in_     | in  | tdata: sensor_x, sensor_y, sensor_z, brightness; tuser: start_map
// out_    | out | tdata: world_x, world_y, world_z, gray; tuser: overflow
// cfg_    | in  | write enable, register index, 63-bit data
// Steps: accept, the transform (one 21x42 multiply per cycle, 3 per row plus a rounding
// step, 3 rows per stage, 2 stages), the keys, the hash, then a read and a check per
// probe on the registered-read table memory, up to PROBE_LIMIT probes, and the load
// of the output register. One point is in work at a time.
// After reset and on start_map, a clearing pass walks the valid memory, one
// entry per cycle, holding in_tready low.
// out_tready low holds the finished result and stalls the next point at its end.
module point_transform_voxel_dedup_filter #(
  parameter int unsigned TABLE_ENTRIES = 65536,
  parameter int unsigned PROBE_LIMIT = 8
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  // sensor_x[20:0], sensor_y[41:21], sensor_z[62:42], brightness[70:63], zero pad
  input  wire  [ptvdf_pkg::InDataW-1:0] in_tdata,
  // start_map
  input  wire                          in_tuser,
  output logic                         out_tvalid,
  input  wire                          out_tready,
  // world_x[20:0], world_y[41:21], world_z[62:42], gray[70:63], zero pad
  output logic [ptvdf_pkg::OutDataW-1:0] out_tdata,
  // overflow
  output logic                         out_tuser,
  input  wire                          cfg_wen,
  input  wire  [ptvdf_pkg::RegIdxW-1:0] cfg_addr,
  input  wire  [ptvdf_pkg::RegW-1:0]   cfg_wdata
);
  import ptvdf_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam int unsigned PW = $clog2(PROBE_LIMIT + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CLEAR = 4'd1;
  localparam logic [3:0] S_MAC   = 4'd2;
  localparam logic [3:0] S_ROW   = 4'd3;
  localparam logic [3:0] S_KEY   = 4'd4;
  localparam logic [3:0] S_HASH  = 4'd5;
  localparam logic [3:0] S_READ  = 4'd6;
  localparam logic [3:0] S_CHECK = 4'd7;
  localparam logic [3:0] S_EMIT  = 4'd8;

  logic [RegW-1:0] regs_r [8];
  logic [3:0] state_r;
  logic [AW-1:0] clr_r;
  logic pend_r;
  logic stage_r;
  logic [1:0] row_r, col_r;
  logic signed [CoordW+20:0] vin_r [3];
  logic signed [CoordW+20:0] vout_r [3];
  logic signed [63:0] acc_r;
  logic signed [63:0] prod_r;
  logic prod_v_r;
  logic [7:0] bright_r;
  coord_t world_r [3];
  logic signed [KeyW-1:0] key_r [3];
  logic [63:0] h_r;
  logic [1:0] hstep_r;
  logic [AW-1:0] slot_r;
  logic [PW-1:0] probe_r;
  logic ovf_r;

  logic valid_mem [TABLE_ENTRIES];
  vkey_t key_mem [TABLE_ENTRIES];
  logic vrd_r;
  vkey_t krd_r;

  logic out_valid_r;
  logic [OutDataW-1:0] out_data_r;
  logic out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r[0] <= RowReset0; regs_r[1] <= RowReset1;
      regs_r[2] <= RowReset2; regs_r[3] <= '0;
      regs_r[4] <= RowReset0; regs_r[5] <= RowReset1;
      regs_r[6] <= RowReset2; regs_r[7] <= '0;
    end else if (cfg_wen) begin
      regs_r[cfg_addr] <= cfg_wdata;
    end
  end

  logic [2:0] base;
  logic signed [20:0] coef;
  logic signed [20:0] ofs;
  logic signed [63:0] rsum;
  logic signed [63:0] rnd;
  logic signed [63:0] satv;
  logic signed [63:0] scaled;
  vkey_t pk;
  logic do_clear_wr;
  logic wr_en;

  always_comb begin
    base = stage_r ? 3'd4 : 3'd0;
    coef = regs_r[base + {1'b0, row_r}][21*col_r +: 21];
    ofs = regs_r[base + 3'd3][21*row_r +: 21];
    rsum = acc_r + prod_r + 64'sd131072;
    rnd = (rsum >>> 18) + 64'(ofs);
    pk = {key_r[0], key_r[1], key_r[2]};
    satv = 64'(vout_r[row_r]);
    if (satv > 64'sd1048575) satv = 64'sd1048575;
    else if (satv < -64'sd1048576) satv = -64'sd1048576;
    scaled = (satv * 64'sd100) >>> 10;
  end

  assign in_tready = (state_r == S_IDLE) && !pend_r;
  assign do_clear_wr = (state_r == S_CLEAR);
  assign wr_en = (state_r == S_CHECK) && !vrd_r;

  always_ff @(posedge clk) begin
    if (do_clear_wr) valid_mem[clr_r] <= 1'b0;
    else if (wr_en) valid_mem[slot_r] <= 1'b1;
    if (wr_en) key_mem[slot_r] <= pk;
    vrd_r <= valid_mem[slot_r];
    krd_r <= key_mem[slot_r];
  end

  always_ff @(posedge clk) begin
    prod_r <= 64'(coef) * 64'(vin_r[col_r]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      pend_r <= 1'b0;
      out_valid_r <= 1'b0;
      prod_v_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && (state_r != S_EMIT)) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            vin_r[0] <= 42'(signed'(in_tdata[20:0]));
            vin_r[1] <= 42'(signed'(in_tdata[41:21]));
            vin_r[2] <= 42'(signed'(in_tdata[62:42]));
            bright_r <= in_tdata[70:63];
            stage_r <= 1'b0; row_r <= '0; col_r <= '0;
            acc_r <= '0; prod_v_r <= 1'b0;
            if (in_tuser) begin
              state_r <= S_CLEAR; clr_r <= '0; pend_r <= 1'b1;
            end else state_r <= S_MAC;
          end
        end
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == AW'(TABLE_ENTRIES - 1)) begin
            state_r <= pend_r ? S_MAC : S_IDLE;
            pend_r <= 1'b0;
          end
        end
        S_MAC: begin
          prod_v_r <= 1'b1;
          if (prod_v_r) acc_r <= acc_r + prod_r;
          if (col_r == 2'd2) state_r <= S_ROW;
          else col_r <= col_r + 1'b1;
        end
        S_ROW: begin
          vout_r[row_r] <= 42'(rnd);
          prod_v_r <= 1'b0;
          acc_r <= '0;
          col_r <= '0;
          if (row_r == 2'd2) begin
            row_r <= '0;
            if (stage_r) state_r <= S_KEY;
            else begin
              stage_r <= 1'b1;
              vin_r[0] <= vout_r[0]; vin_r[1] <= vout_r[1];
              vin_r[2] <= 42'(rnd);
              state_r <= S_MAC;
            end
          end else begin
            row_r <= row_r + 1'b1;
            state_r <= S_MAC;
          end
        end
        S_KEY: begin
          world_r[row_r] <= CoordW'(satv);
          key_r[row_r] <= KeyW'(scaled);
          if (row_r == 2'd2) begin
            state_r <= S_HASH; hstep_r <= '0;
          end else row_r <= row_r + 1'b1;
        end
        S_HASH: begin
          hstep_r <= hstep_r + 1'b1;
          unique case (hstep_r)
            2'd0: h_r <= 64'(key_r[0]);
            2'd1: h_r <= (h_r * HashMul) ^ 64'(key_r[1]);
            default: begin
              h_r <= (h_r * HashMul) ^ 64'(key_r[2]);
              slot_r <= AW'((h_r * HashMul) ^ 64'(key_r[2]));
              probe_r <= '0;
              state_r <= S_READ;
            end
          endcase
        end
        S_READ: state_r <= S_CHECK;
        S_CHECK: begin
          if (!vrd_r) begin
            ovf_r <= 1'b0; state_r <= S_EMIT;
          end else if (krd_r == pk) begin
            state_r <= S_IDLE;
          end else if (probe_r == PW'(PROBE_LIMIT - 1)) begin
            ovf_r <= 1'b1; state_r <= S_EMIT;
          end else begin
            probe_r <= probe_r + 1'b1;
            slot_r <= slot_r + 1'b1;
            state_r <= S_READ;
          end
        end
        S_EMIT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r <= {1'b0, bright_r, world_r[2], world_r[1], world_r[0]};
            out_user_r <= ovf_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tuser = out_user_r;
endmodule
`default_nettype wire

### hdl/ptvdf_checker.sv
`default_nettype none
module ptvdf_checker (
  input wire clk,
  input wire rst_n,
  input wire in_tvalid,
  input wire in_tready,
  input wire out_tvalid,
  input wire out_tready,
  input wire [71:0] out_tdata,
  input wire out_tuser
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[71] == 1'b0) else $error("pad bit set");
  a_one_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("second item taken at once");
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid && !in_tready)
    else $error("busy after reset");
endmodule
bind point_transform_voxel_dedup_filter ptvdf_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser));
`default_nettype wire

### tb/testbench.sv
`default_nettype none
module testbench;
  import ptvdf_pkg::*;

  typedef struct {
    coord_t     wx;
    coord_t     wy;
    coord_t     wz;
    logic [7:0] gray;
    logic       ovf;
  } world_point_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [InDataW-1:0]  in_tdata = '0;
  logic                in_tuser = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic                out_tuser;
  logic                cfg_wen = 1'b0;
  logic [RegIdxW-1:0]  cfg_addr = '0;
  logic [RegW-1:0]     cfg_wdata = '0;

  point_transform_voxel_dedup_filter dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_wen(cfg_wen), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  localparam int Slots = 65536;
  localparam int Probes = 8;
  localparam int Settle = 64;

  logic [RegW-1:0] pose_regs [8];
  bit              slot_used [Slots];
  vkey_t           slot_key [Slots];
  world_point_t    pending_points [$];
  int              errors = 0;
  int              idle_pct = 0;
  int              stall_pct = 0;
  logic [62:0]     recent_pts [$];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) out_tready <= ($urandom_range(99) >= stall_pct);

  function automatic longint coef(logic [RegW-1:0] r, int j);
    logic signed [20:0] f;
    f = r[21*j +: 21];
    return longint'(f);
  endfunction

  function automatic void rigid_stage(int base, input longint v[3], output longint o[3]);
    longint s;
    for (int r = 0; r < 3; r++) begin
      s = 0;
      for (int c = 0; c < 3; c++) s += coef(pose_regs[base + r], c) * v[c];
      s += longint'(1) << 17;
      o[r] = (s >>> 18) + coef(pose_regs[base + 3], r);
    end
  endfunction

  function automatic bit predict_point(bit clear, logic [62:0] xyz, logic [7:0] b,
                                       output world_point_t res);
    longint p[3], body[3], w[3], k[3];
    longint unsigned h;
    vkey_t  vk;
    int     slot;
    if (clear) foreach (slot_used[i]) slot_used[i] = 0;
    for (int i = 0; i < 3; i++) p[i] = coef({1'b0, xyz[62:0]}, i);
    rigid_stage(0, p, body);
    rigid_stage(4, body, w);
    for (int i = 0; i < 3; i++) begin
      if (w[i] > 1048575) w[i] = 1048575;
      if (w[i] < -1048576) w[i] = -1048576;
      k[i] = (w[i] * 100) >>> 10;
    end
    vk = {k[0][17:0], k[1][17:0], k[2][17:0]};
    h = k[0];
    h = (h * HashMul) ^ k[1];
    h = (h * HashMul) ^ k[2];
    res.wx = w[0][20:0];
    res.wy = w[1][20:0];
    res.wz = w[2][20:0];
    res.gray = b;
    res.ovf = 1'b1;
    for (int i = 0; i < Probes; i++) begin
      slot = (h[15:0] + i) % Slots;
      if (!slot_used[slot]) begin
        slot_used[slot] = 1;
        slot_key[slot] = vk;
        res.ovf = 1'b0;
        break;
      end
      if (slot_key[slot] == vk) return 0;
    end
    return 1;
  endfunction

  task automatic send_point(bit clear, logic [62:0] xyz, logic [7:0] b);
    world_point_t res;
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= clear;
    in_tdata <= {1'b0, b, xyz};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (predict_point(clear, xyz, b, res))
      pending_points.insert(pending_points.size(), res);
  endtask

  task automatic write_reg(logic [RegIdxW-1:0] idx, logic [RegW-1:0] val);
    @(posedge clk);
    in_tvalid <= 1'b0;
    cfg_wen <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    pose_regs[idx] = val;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic drain;
    @(posedge clk);
    in_tvalid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (Settle) @(posedge clk);
  endtask

  task automatic load_identity;
    write_reg(REG_EXT_ROW0, RowReset0);
    write_reg(REG_EXT_ROW1, RowReset1);
    write_reg(REG_EXT_ROW2, RowReset2);
    write_reg(REG_EXT_OFS, '0);
    write_reg(REG_POSE_ROW0, RowReset0);
    write_reg(REG_POSE_ROW1, RowReset1);
    write_reg(REG_POSE_ROW2, RowReset2);
    write_reg(REG_POSE_OFS, '0);
  endtask

  function automatic logic [20:0] coord_for_key(longint k);
    longint w;
    w = (k * 1024) / 100;
    while (((w * 100) >>> 10) < k) w++;
    while (((w * 100) >>> 10) > k) w--;
    return w[20:0];
  endfunction

  function automatic logic [62:0] rand_xyz;
    return {21'($urandom_range(21'h1FFFFF)), 21'($urandom_range(21'h1FFFFF)),
            21'($urandom_range(21'h1FFFFF))};
  endfunction

  task automatic test_field_extremes;
    send_point(1'b1, {21'h100000, 21'h0FFFFF, 21'h100000}, 8'd0);
    send_point(1'b0, {21'h0FFFFF, 21'h100000, 21'h0FFFFF}, 8'd255);
    send_point(1'b0, 63'h7FFFFFFFFFFFFFFF, 8'hAA);
    send_point(1'b0, 63'd0, 8'h55);
    send_point(1'b0, 63'd0, 8'h01);
    drain();
  endtask

  task automatic test_probe_overflow;
    longint lows[3] = '{1000 - 65536, 1000, 1000 + 65536};
    send_point(1'b1, {coord_for_key(5), coord_for_key(lows[1]), coord_for_key(lows[1])},
               8'd9);
    for (int a = 0; a < 3; a++)
      for (int c = 0; c < 3; c++)
        if (a != 1 || c != 1)
          send_point(1'b0, {coord_for_key(5), coord_for_key(lows[c]), coord_for_key(lows[a])},
                     8'(a * 3 + c));
    send_point(1'b0, {coord_for_key(5), coord_for_key(lows[0]), coord_for_key(lows[0])},
               8'd77);
    drain();
  endtask

  task automatic test_saturation;
    write_reg(REG_POSE_ROW0, {21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF});
    write_reg(REG_POSE_ROW1, {21'h100000, 21'h100000, 21'h100000});
    write_reg(REG_POSE_ROW2, {21'h100000, 21'h0, 21'h0FFFFF});
    write_reg(REG_POSE_OFS, {21'h100000, 21'h0FFFFF, 21'h100000});
    write_reg(REG_EXT_OFS, {21'h0FFFFF, 21'h100000, 21'h0FFFFF});
    send_point(1'b0, {21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF}, 8'd3);
    send_point(1'b0, {21'h100000, 21'h100000, 21'h100000}, 8'd4);
    send_point(1'b0, {21'h000001, 21'h1FFFFF, 21'h000400}, 8'd5);
    drain();
    load_identity();
  endtask

  task automatic load_random_pose(bit wild);
    for (int i = 0; i < 8; i++) begin
      logic [RegW-1:0] v;
      v = RegW'({$urandom, $urandom});
      if (!wild && (i % 4) != 3)
        for (int j = 0; j < 3; j++)
          v[21*j +: 21] = ((i % 4) == j ? 21'd262144 : 21'd0) + 21'($urandom_range(8192))
                          - 21'd4096;
      write_reg(RegIdxW'(i), v);
    end
  endtask

  task automatic test_random_traffic(int n, int idle, int stall, bit wild);
    logic [62:0] xyz;
    load_random_pose(wild);
    idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      if (recent_pts.size() != 0 && $urandom_range(99) < 40) begin
        xyz = recent_pts[$urandom_range(recent_pts.size() - 1)];
        if ($urandom_range(1)) xyz[3:0] = 4'($urandom);
      end else begin
        xyz = rand_xyz();
        if ($urandom_range(3) == 0) xyz = {3{21'($signed(16'($urandom)))}} ^ 63'($urandom);
        recent_pts.insert(recent_pts.size(), xyz);
        if (recent_pts.size() > 64) void'(recent_pts.pop_front());
      end
      send_point(i == n / 2, xyz, 8'($urandom));
    end
    drain();
  endtask

  always @(posedge clk) begin
    world_point_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_points.size() == 0) begin
        $error("unexpected result transaction %h", out_tdata);
        errors++;
      end else begin
        e = pending_points.pop_front();
        if (out_tdata[20:0] !== e.wx) begin
          $error("world_x exp %0d got %0d", e.wx, $signed(out_tdata[20:0]));
          errors++;
        end
        if (out_tdata[41:21] !== e.wy) begin
          $error("world_y exp %0d got %0d", e.wy, $signed(out_tdata[41:21]));
          errors++;
        end
        if (out_tdata[62:42] !== e.wz) begin
          $error("world_z exp %0d got %0d", e.wz, $signed(out_tdata[62:42]));
          errors++;
        end
        if (out_tdata[70:63] !== e.gray) begin
          $error("gray exp %0d got %0d", e.gray, out_tdata[70:63]);
          errors++;
        end
        if (out_tuser !== e.ovf) begin
          $error("overflow exp %0d got %0d", e.ovf, out_tuser);
          errors++;
        end
      end
    end
  end

  initial begin
    pose_regs = '{RowReset0, RowReset1, RowReset2, '0, RowReset0, RowReset1, RowReset2, '0};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_field_extremes();
    test_probe_overflow();
    test_saturation();
    test_random_traffic(220, 0, 0, 1'b0);
    test_random_traffic(220, 80, 0, 1'b0);
    test_random_traffic(220, 0, 80, 1'b1);
    test_random_traffic(220, 29, 29, 1'b0);
    test_random_traffic(220, 0, 0, 1'b1);
    test_random_traffic(220, 80, 0, 1'b0);
    test_random_traffic(220, 0, 80, 1'b0);
    test_random_traffic(220, 29, 29, 1'b0);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #(12 * 6000000);
    $display("FAILURE");
    $finish;
  end
endmodule
`default_nettype wire

### files.f
hdl/ptvdf_pkg.sv
hdl/point_transform_voxel_dedup_filter.sv
hdl/ptvdf_checker.sv
tb/testbench.sv
